>>> hdl/slot_array_priority_queue_macros.svh
// assertion macros shared by the checker of the slot array priority queue
`ifndef SLOT_ARRAY_PRIORITY_QUEUE_MACROS_SVH
`define SLOT_ARRAY_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SPAQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slot array priority queue check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define SPAQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slot array priority queue check failed");

`endif

>>> hdl/spaq_pkg.sv
// types, sizes and codes of the slot array priority queue
package spaq_pkg;

  localparam int SLOTS = 16;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int VAL_W = 32;
  localparam int PRI_W = 16;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FREE,
    S_SCAN,
    S_LAST,
    S_DONE
  } state_t;

  // one slot as stored in the memory
  typedef struct packed {
    logic [PRI_W-1:0]        pri;
    logic signed [VAL_W-1:0] val;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  // memory access request from the sequencer
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    slot_t            wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  // finished result handed to the output register
  typedef struct packed {
    status_t                 status;
    logic signed [VAL_W-1:0] value;
  } res_t;

endpackage

>>> hdl/spaq_in_if.sv
// input channel of the slot array priority queue
interface spaq_in_if;
  import spaq_pkg::*;

  logic                    valid;
  logic                    ready;
  op_t                     opcode;
  logic signed [VAL_W-1:0] item_value;
  logic [PRI_W-1:0]        item_priority;

  modport source (output valid, opcode, item_value, item_priority, input ready);
  modport sink (input valid, opcode, item_value, item_priority, output ready);
endinterface

>>> hdl/spaq_out_if.sv
// result channel of the slot array priority queue
interface spaq_out_if;
  import spaq_pkg::*;

  logic                    valid;
  logic                    ready;
  status_t                 status;
  logic signed [VAL_W-1:0] out_value;

  modport source (output valid, status, out_value, input ready);
  modport sink (input valid, status, out_value, output ready);
endinterface

>>> hdl/spaq_ram.sv
// generic single-clock ram, one write and one registered read port
module spaq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 48,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/spaq_ctrl.sv
// sequencer: valid marks, free-slot search and priority scan over the slot memory
module spaq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  spaq_in_if.sink           in_ch,
  output spaq_pkg::ram_req_t ram_req,
  input  spaq_pkg::slot_t   rdata,
  output logic              res_valid,
  input  logic              res_ready,
  output spaq_pkg::res_t    res
);
  import spaq_pkg::*;

  state_t                  state_r, state_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [SLOTS-1:0]        valid_r, valid_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic signed [VAL_W-1:0] val_r, val_nxt;
  logic [PRI_W-1:0]        pri_r, pri_nxt;
  logic                    rd_pend_r, rd_pend_nxt;
  logic                    rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]        rd_idx_r, rd_idx_nxt;
  logic                    have_best_r, have_best_nxt;
  logic [IDX_W-1:0]        best_idx_r, best_idx_nxt;
  logic [PRI_W-1:0]        best_pri_r, best_pri_nxt;
  logic signed [VAL_W-1:0] best_val_r, best_val_nxt;
  res_t                    res_r, res_nxt;
  logic                    upd;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      count_r     <= '0;
      rd_pend_r   <= 1'b0;
      have_best_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      count_r     <= count_nxt;
      rd_pend_r   <= rd_pend_nxt;
      have_best_r <= have_best_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    val_r      <= val_nxt;
    pri_r      <= pri_nxt;
    rd_vld_r   <= rd_vld_nxt;
    rd_idx_r   <= rd_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_pri_r <= best_pri_nxt;
    best_val_r <= best_val_nxt;
    res_r      <= res_nxt;
  end

  // a slot read last cycle beats the best so far; ties keep the lower index
  assign upd = rd_pend_r && rd_vld_r && (!have_best_r || (rdata.pri > best_pri_r));

  // next state and outputs
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    valid_nxt     = valid_r;
    count_nxt     = count_r;
    val_nxt       = val_r;
    pri_nxt       = pri_r;
    rd_pend_nxt   = 1'b0;
    rd_vld_nxt    = rd_vld_r;
    rd_idx_nxt    = rd_idx_r;
    have_best_nxt = have_best_r;
    best_idx_nxt  = best_idx_r;
    best_pri_nxt  = best_pri_r;
    best_val_nxt  = best_val_r;
    res_nxt       = res_r;
    ram_req       = '0;
    in_ch.ready   = 1'b0;
    res_valid     = 1'b0;

    if (upd) begin
      have_best_nxt = 1'b1;
      best_idx_nxt  = rd_idx_r;
      best_pri_nxt  = rdata.pri;
      best_val_nxt  = rdata.val;
    end

    case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          val_nxt       = in_ch.item_value;
          pri_nxt       = in_ch.item_priority;
          idx_nxt       = '0;
          have_best_nxt = 1'b0;
          if (in_ch.opcode == OP_ENQ) begin
            if (count_r == CNT_W'(SLOTS)) begin
              res_nxt.status = ST_FULL;
              res_nxt.value  = '0;
              state_nxt      = S_DONE;
            end else begin
              state_nxt = S_FREE;
            end
          end else begin
            if (count_r == '0) begin
              res_nxt.status = ST_EMPTY;
              res_nxt.value  = '0;
              state_nxt      = S_DONE;
            end else begin
              state_nxt = S_SCAN;
            end
          end
        end
      end

      // one valid mark per cycle until the first free slot
      S_FREE: begin
        if (!valid_r[idx_r]) begin
          ram_req.we        = 1'b1;
          ram_req.waddr     = idx_r;
          ram_req.wdata.pri = pri_r;
          ram_req.wdata.val = val_r;
          valid_nxt[idx_r]  = 1'b1;
          count_nxt         = count_r + CNT_W'(1);
          res_nxt.status    = ST_OK;
          res_nxt.value     = '0;
          state_nxt         = S_DONE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      // read one slot per cycle, compare it when its data returns
      S_SCAN: begin
        ram_req.re  = 1'b1;
        ram_req.raddr = idx_r;
        rd_pend_nxt = 1'b1;
        rd_idx_nxt  = idx_r;
        rd_vld_nxt  = valid_r[idx_r];
        if (idx_r == IDX_W'(SLOTS - 1)) begin
          state_nxt = S_LAST;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      // last compare done in upd; free the winner
      S_LAST: begin
        if (upd) begin
          valid_nxt[rd_idx_r] = 1'b0;
          res_nxt.value       = rdata.val;
        end else begin
          valid_nxt[best_idx_r] = 1'b0;
          res_nxt.value         = best_val_r;
        end
        res_nxt.status = ST_OK;
        count_nxt      = count_r - CNT_W'(1);
        state_nxt      = S_DONE;
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res = res_r;

endmodule

>>> hdl/slot_array_priority_queue.sv
// slot array priority queue: enqueue to first free slot, dequeue highest priority
// a full enqueue or an empty dequeue goes straight to its result; an enqueue walks the
//   valid marks up to the first free slot, and a dequeue reads and compares every slot
// one item at a time, each held by the sequencer for the slot-by-slot walk
// the output register frees the sequencer, so the next item starts while a result waits
// reset (rst_n low, synchronous) clears all valid marks and the count; no clearing pass
module slot_array_priority_queue (
  input  logic      clk,
  input  logic      rst_n,
  spaq_in_if.sink   in_ch,
  spaq_out_if.source out_ch
);
  import spaq_pkg::*;

  ram_req_t ram_req;
  slot_t    rdata;
  logic     res_valid;
  logic     res_ready;
  res_t     res;

  logic                    out_valid_r;
  status_t                 out_status_r;
  logic signed [VAL_W-1:0] out_value_r;

  // sequencer
  spaq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .ram_req   (ram_req),
    .rdata     (rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // slot memory: priority and value of each slot
  spaq_ram #(
    .DEPTH (SLOTS),
    .WIDTH (SLOT_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (rdata)
  );

  // output register
  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_status_r <= res.status;
      out_value_r  <= res.value;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.out_value = out_value_r;

endmodule

>>> hdl/spaq_checker.sv
// port checker of the slot array priority queue and its bind
`include "slot_array_priority_queue_macros.svh"

module spaq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [31:0] out_value
);
  import spaq_pkg::*;

  // a stalled result keeps its valid and payload
  `SPAQ_ASSERT_NXT(a_out_hold_valid, out_valid && !out_ready, out_valid)
  `SPAQ_ASSERT_NXT(a_out_hold_data, out_valid && !out_ready, $stable(out_status) && $stable(out_value))
  // full and empty reports carry a zero value
  `SPAQ_ASSERT_IMP(a_err_zero, out_valid && (out_status == ST_FULL || out_status == ST_EMPTY), out_value == '0)
  // one item at a time: no new item right after one is taken
  `SPAQ_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready)

endmodule

bind slot_array_priority_queue spaq_checker u_spaq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_value  (out_ch.out_value)
);

>>> verif/slot_array_priority_queue_tb.sv
// self-checking testbench of the slot array priority queue: directed plan, then biased random
module slot_array_priority_queue_tb;
  import spaq_pkg::*;

  localparam int N_ITEMS     = 1950;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_WAIT  = SLOTS + 8;

  // one row of the directed plan; chk set means the result is written out here
  typedef struct {
    op_t                     op;
    logic signed [VAL_W-1:0] value;
    logic [PRI_W-1:0]        prio;
    bit                      chk;
    status_t                 st;
    logic signed [VAL_W-1:0] res;
  } plan_row_t;

  localparam int N_PLAN = 25;

  plan_row_t directed_plan [N_PLAN] = '{
    '{OP_DEQ, 32'sh12345678, 16'h00AA, 1'b1, ST_EMPTY, 32'sd0},
    '{OP_ENQ, 32'sh7FFFFFFF, 16'h0000, 1'b1, ST_OK,    32'sd0},
    '{OP_ENQ, 32'sh80000000, 16'hFFFF, 1'b1, ST_OK,    32'sd0},
    '{OP_DEQ, 32'sd0,        16'h0000, 1'b1, ST_OK,    32'sh80000000},
    '{OP_DEQ, 32'sd0,        16'h0000, 1'b1, ST_OK,    32'sh7FFFFFFF},
    '{OP_DEQ, 32'sd0,        16'h0000, 1'b1, ST_EMPTY, 32'sd0},
    '{OP_ENQ, -32'sd1,       16'h0003, 1'b1, ST_OK,    32'sd0},
    '{OP_ENQ, 32'sd0,        16'h0009, 1'b1, ST_OK,    32'sd0},
    '{OP_ENQ, 32'sd1,        16'h0009, 1'b1, ST_OK,    32'sd0},
    '{OP_ENQ, 32'sh55555555, 16'h0000, 1'b1, ST_OK,    32'sd0},
    '{OP_ENQ, 32'shAAAAAAAA, 16'hFFFF, 1'b1, ST_OK,    32'sd0},
    '{OP_ENQ, 32'sh0F0F0F0F, 16'hFFFF, 1'b1, ST_OK,    32'sd0},
    '{OP_ENQ, 32'sd42,       16'h0001, 1'b1, ST_OK,    32'sd0},
    '{OP_ENQ, -32'sd42,      16'h8000, 1'b1, ST_OK,    32'sd0},
    '{OP_ENQ, 32'sh7FFFFFFF, 16'h7FFF, 1'b1, ST_OK,    32'sd0},
    '{OP_ENQ, 32'sh80000000, 16'h0009, 1'b1, ST_OK,    32'sd0},
    '{OP_ENQ, 32'sd1000,     16'h0002, 1'b1, ST_OK,    32'sd0},
    '{OP_ENQ, -32'sd1000,    16'hFFFE, 1'b1, ST_OK,    32'sd0},
    '{OP_ENQ, 32'sh00FF00FF, 16'h0000, 1'b1, ST_OK,    32'sd0},
    '{OP_ENQ, 32'shFF00FF00, 16'h0001, 1'b1, ST_OK,    32'sd0},
    '{OP_ENQ, 32'sd77,       16'h8000, 1'b1, ST_OK,    32'sd0},
    '{OP_ENQ, -32'sd77,      16'hFFFF, 1'b1, ST_OK,    32'sd0},
    '{OP_ENQ, 32'sh13579BDF, 16'h1234, 1'b1, ST_FULL,  32'sd0},
    '{OP_DEQ, 32'sd0,        16'h0000, 1'b0, ST_OK,    32'sd0},
    '{OP_ENQ, 32'sh2468ACE0, 16'hFFFF, 1'b0, ST_OK,    32'sd0}
  };

  logic clk = 1'b0;
  logic rst_n;

  spaq_in_if  in_ch ();
  spaq_out_if out_ch ();

  slot_array_priority_queue dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  // shadow copy of the slot array
  logic signed [VAL_W-1:0] held_val [SLOTS];
  logic [PRI_W-1:0]        held_pri [SLOTS];
  bit                      held     [SLOTS];

  res_t pq_replies_due [$];

  int n_enq, n_full, n_deq, n_empty, n_checked, n_errors;
  int idle_cycles;
  bit sender_quiet, receiver_quiet;

  // apply one request to the shadow array and return the reply it must produce
  function automatic res_t pq_serve(input op_t op, input logic signed [VAL_W-1:0] value,
                                    input logic [PRI_W-1:0] prio);
    int   pick;
    res_t r;
    r.status = ST_OK;
    r.value  = '0;
    pick     = -1;
    if (op == OP_ENQ) begin
      n_enq++;
      for (int i = 0; i < SLOTS; i++) begin
        if (!held[i] && pick < 0) pick = i;
      end
      if (pick < 0) begin
        r.status = ST_FULL;
        n_full++;
      end else begin
        held_val[pick] = value;
        held_pri[pick] = prio;
        held[pick]     = 1'b1;
      end
    end else begin
      n_deq++;
      // strictly greater keeps the lowest index on ties
      for (int i = 0; i < SLOTS; i++) begin
        if (held[i] && (pick < 0 || held_pri[i] > held_pri[pick])) pick = i;
      end
      if (pick < 0) begin
        r.status = ST_EMPTY;
        n_empty++;
      end else begin
        r.value    = held_val[pick];
        held[pick] = 1'b0;
      end
    end
    return r;
  endfunction

  // present one item after a gap, entered and left at a falling edge
  task automatic send_item(input op_t op, input logic signed [VAL_W-1:0] value,
                           input logic [PRI_W-1:0] prio, input bit chk,
                           input status_t st, input logic signed [VAL_W-1:0] res);
    int   gap;
    res_t r;
    gap = sender_quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.opcode        <= op;
    in_ch.item_value    <= value;
    in_ch.item_priority <= prio;
    do @(posedge clk); while (!in_ch.ready);
    r = pq_serve(op, value, prio);
    if (chk) begin
      r.status = st;
      r.value  = res;
    end
    pq_replies_due.push_back(r);
    @(negedge clk);
  endtask

  // hold off new items until every reply is back
  task automatic drain_replies();
    in_ch.valid <= 1'b0;
    while (pq_replies_due.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // stimulus
  initial begin
    int                      enq_bias;
    int                      prio_mode;
    op_t                     op;
    logic signed [VAL_W-1:0] value;
    logic [PRI_W-1:0]        prio;

    for (int i = 0; i < SLOTS; i++) held[i] = 1'b0;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.opcode        = OP_ENQ;
    in_ch.item_value    = '0;
    in_ch.item_priority = '0;
    enq_bias            = 50;
    prio_mode           = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed plan
    foreach (directed_plan[k]) begin
      send_item(directed_plan[k].op, directed_plan[k].value, directed_plan[k].prio,
                directed_plan[k].chk, directed_plan[k].st, directed_plan[k].res);
    end
    drain_replies();

    // random part, with the enqueue share swept so the queue fills and empties often
    for (int i = 0; i < N_ITEMS - N_PLAN; i++) begin
      if (i % 64 == 0) begin
        case ($urandom_range(0, 2))
          0: enq_bias = 15;
          1: enq_bias = 50;
          default: enq_bias = 85;
        endcase
        prio_mode    = $urandom_range(0, 2);
        sender_quiet = ($urandom_range(0, 3) == 0);
      end
      if (i == (N_ITEMS - N_PLAN) / 2) drain_replies();
      op = ($urandom_range(0, 99) < enq_bias) ? OP_ENQ : OP_DEQ;
      // full-range priorities, or four levels that give many ties
      case (prio_mode)
        0: prio = PRI_W'($urandom_range(0, 65535));
        1: prio = PRI_W'($urandom_range(0, 3));
        default: begin
          case ($urandom_range(0, 3))
            0: prio = 16'h0000;
            1: prio = 16'hFFFF;
            2: prio = 16'h7FFF;
            default: prio = 16'h8000;
          endcase
        end
      endcase
      if ($urandom_range(0, 7) == 0) begin
        value = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      end else begin
        value = $urandom;
      end
      send_item(op, value, prio, 1'b0, ST_OK, '0);
    end
    in_ch.valid <= 1'b0;

    // wait for the last replies, then a little longer for strays
    while (pq_replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d enqueues (%0d refused as full) and %0d dequeues (%0d on empty)",
             n_enq, n_full, n_deq, n_empty);
    $display("%0d replies checked, %0d mismatches", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // result side: random stalls, compare each reply with the oldest one due
  initial begin
    int   stall;
    int   n_seen;
    res_t due;
    out_ch.ready = 1'b0;
    n_seen       = 0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (n_seen % 50 == 0) receiver_quiet = ($urandom_range(0, 3) == 0);
      stall = receiver_quiet ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      n_seen++;
      if (pq_replies_due.size() == 0) begin
        $error("unexpected reply: status %0d value %0d", out_ch.status, out_ch.out_value);
        n_errors++;
      end else begin
        due = pq_replies_due.pop_front();
        n_checked++;
        if (out_ch.status !== due.status) begin
          $error("status mismatch: expected %0d, got %0d", due.status, out_ch.status);
          n_errors++;
        end
        if (out_ch.out_value !== due.value) begin
          $error("out_value mismatch: expected %0d, got %0d", due.value, out_ch.out_value);
          n_errors++;
        end
      end
      @(negedge clk);
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $error("no item moved for %0d cycles", STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule
